// ----- hw/rtl/cht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Commands, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int unsigned BUCKETS_DEF = 256;
   localparam int unsigned POOL_DEF    = 64;
   localparam int unsigned KEY_W       = 32;
   localparam int unsigned VAL_W       = 32;
   localparam int unsigned BCFG_W      = 9;
   localparam int unsigned CNT_W       = 7;

   localparam logic [1:0] CMD_GET    = 2'd0;
   localparam logic [1:0] CMD_PUT    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_HEAD,
      ST_HEAD_WAIT,
      ST_WALK,
      ST_WALK_WAIT,
      ST_FREE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_start;  // begin clearing pass
      logic load;         // capture request
      logic mod_start;    // start bucket reduction
      logic head_read;    // issue head memory read
      logic head_take;    // latch head pointer as current
      logic entry_read;   // issue entry read of current slot
      logic entry_check;  // compare fetched entry, advance
      logic free_start;   // start free slot search
      logic commit;       // apply the update
      logic respond;      // drive the response
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic cur_null;     // current pointer is null or walk bound reached
      logic hit;          // compare matched
      logic free_done;
      logic cmd_valid;
   } sts_type;

endpackage

// ----- hw/rtl/chained_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table: key-to-value map with separate chaining
// Get, put and remove over a bucket head memory and a fixed entry pool.
//
//   channel   ports                          flow
//   request   start, busy, req_*             in, taken when start && !busy
//   response  rsp_valid, rsp_*               out, one cycle, no backpressure
//   config    csr_write, csr_data            in, write while idle
//
// Busy stays high through the bit-serial key reduction, the head read, an
// entry read and compare per chain entry visited, then the update and the
// response; a miss also ends the walk and passes the free slot search, which
// for a new put scans up from slot 0 to the first free slot (all when full).
// An unknown command skips reduction and walk and is answered directly.
// After reset, and after each configuration write while idle, a clearing
// pass sweeps the head memory with busy high.
// The response cannot be stalled; it shows in the first idle cycle.
// ----------------------------------------------------------------------------
module chained_hash_table #(
   parameter int unsigned BUCKETS      = cht_pkg::BUCKETS_DEF,
   parameter int unsigned POOL_ENTRIES = cht_pkg::POOL_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [cht_pkg::KEY_W-1:0]    req_key,
   input  logic [cht_pkg::VAL_W-1:0]    req_value,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [cht_pkg::VAL_W-1:0]    rsp_data,
   output logic                         rsp_status,
   output logic [cht_pkg::CNT_W-1:0]    rsp_entry_count,
   input  logic                         csr_write,
   input  logic [cht_pkg::BCFG_W-1:0]   csr_data
);
   import cht_pkg::*;

   ctl_type ctl;
   sts_type sts;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_write (csr_write),
      .sts       (sts),
      .ctl       (ctl),
      .busy      (busy)
   );

   cht_dpath #(
      .BUCKETS      (BUCKETS),
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .csr_write       (csr_write),
      .csr_data        (csr_data),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_data        (rsp_data),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // a response never appears while idle-ready without a request
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without operation");

   // a refused put never reports found
   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_found) else $error("full with hit");

   // not found means zero data
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_data == '0) else $error("stale data");

   // entry count stays within the pool
   a_count_rng: assert property (@(posedge clock) disable iff (reset)
      32'(rsp_entry_count) <= POOL_ENTRIES) else $error("count overflow");

endmodule

// ----- hw/rtl/cht_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_ctrl: controller of the chained hash table
// Sequences clear, bucket reduction, chain walk, free search and update.
// ----------------------------------------------------------------------------
module cht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             csr_write,
   input  cht_pkg::sts_type sts,
   output cht_pkg::ctl_type ctl,
   output logic             busy
);
   import cht_pkg::*;

   state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands; a configuration write holds off the request
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = (state_ff != ST_IDLE) || csr_write;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (csr_write) begin
               ctl.clear_start = 1'b1;
               state_in        = ST_CLEAR;
            end else if (start) begin
               ctl.load  = 1'b1;
               state_in  = ST_MOD;
            end
         end
         ST_MOD: begin
            if (!sts.cmd_valid) begin
               state_in = ST_DONE;
            end else if (sts.mod_done) begin
               ctl.head_read = 1'b1;
               state_in      = ST_HEAD;
            end
         end
         ST_HEAD: begin
            state_in = ST_HEAD_WAIT;
         end
         ST_HEAD_WAIT: begin
            ctl.head_take = 1'b1;
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            if (sts.cur_null) begin
               ctl.free_start = 1'b1;
               state_in       = ST_FREE;
            end else begin
               ctl.entry_read = 1'b1;
               state_in       = ST_WALK_WAIT;
            end
         end
         ST_WALK_WAIT: begin
            ctl.entry_check = 1'b1;
            state_in        = sts.hit ? ST_UPDATE : ST_WALK;
         end
         ST_FREE: begin
            if (sts.free_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ctl.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            ctl.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/cht_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_dpath: datapath of the chained hash table
// Holds the bucket head memory, entry pool, valid map and count, a
// restoring reducer for key mod bucket count, and the free slot scanner.
// ----------------------------------------------------------------------------
module cht_dpath #(
   parameter int unsigned BUCKETS      = cht_pkg::BUCKETS_DEF,
   parameter int unsigned POOL_ENTRIES = cht_pkg::POOL_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cht_pkg::ctl_type             ctl,
   output cht_pkg::sts_type             sts,
   input  logic                         csr_write,
   input  logic [cht_pkg::BCFG_W-1:0]   csr_data,
   input  logic [1:0]                   req_command,
   input  logic [cht_pkg::KEY_W-1:0]    req_key,
   input  logic [cht_pkg::VAL_W-1:0]    req_value,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic [cht_pkg::VAL_W-1:0]    rsp_data,
   output logic                         rsp_status,
   output logic [cht_pkg::CNT_W-1:0]    rsp_entry_count
);
   import cht_pkg::*;

   localparam int unsigned BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned PW  = $clog2(POOL_ENTRIES + 1);
   localparam int unsigned IW  = $clog2(POOL_ENTRIES);
   localparam int unsigned NW  = $clog2(BUCKETS + 1);
   localparam int unsigned CW  = (BW > IW ? BW : IW) + 1;
   localparam int unsigned SW  = $clog2(KEY_W + 1);
   localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

   // memories
   logic [PW-1:0]    head_mem [BUCKETS];
   logic [KEY_W-1:0] key_mem  [POOL_ENTRIES];
   logic [VAL_W-1:0] val_mem  [POOL_ENTRIES];
   logic [PW-1:0]    link_mem [POOL_ENTRIES];

   logic [BCFG_W-1:0]       bcfg_ff;
   logic [POOL_ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CW-1:0]           clr_ff;
   logic                    clr_busy_ff;
   logic [1:0]              cmd_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [VAL_W-1:0]        val_ff;
   logic [NW-1:0]           div_ff;
   logic [NW-1:0]           rem_ff;
   logic [SW-1:0]           step_ff;
   logic                    mod_busy_ff;
   logic [PW-1:0]           head_rd_ff;
   logic [PW-1:0]           cur_ff;
   logic [PW-1:0]           prev_ff;
   logic [CW-1:0]           walk_ff;
   logic [KEY_W-1:0]        ekey_rd_ff;
   logic [VAL_W-1:0]        eval_rd_ff;
   logic [PW-1:0]           elink_rd_ff;
   logic                    hit_ff;
   logic [PW-1:0]           hit_link_ff;
   logic [VAL_W-1:0]        hit_val_ff;
   logic [PW-1:0]           free_ff;
   logic [CW-1:0]           scan_ff;
   logic                    scan_busy_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_found_ff;
   logic [VAL_W-1:0]        rsp_data_ff;
   logic                    rsp_status_ff;

   logic [NW-1:0]   div_eff;
   logic [NW:0]     rem_sh;
   logic            cmd_ok;
   logic [BW-1:0]   bucket;
   logic [IW-1:0]   cur_idx;
   logic [IW-1:0]   prev_idx;
   logic [IW-1:0]   free_idx;
   logic            is_put_new;
   logic            is_remove;

   assign cmd_ok  = (cmd_ff == CMD_GET) || (cmd_ff == CMD_PUT) ||
                    (cmd_ff == CMD_REMOVE);
   assign bucket  = BW'(rem_ff);
   assign cur_idx  = cur_ff[IW-1:0];
   assign prev_idx = prev_ff[IW-1:0];
   assign free_idx = free_ff[IW-1:0];

   // clamp configured bucket count to 1..BUCKETS
   always_comb begin
      if (bcfg_ff == '0) begin
         div_eff = NW'(1);
      end else if (32'(bcfg_ff) > BUCKETS) begin
         div_eff = NW'(BUCKETS);
      end else begin
         div_eff = NW'(bcfg_ff);
      end
   end

   // configuration register and clearing pass over the head memory
   always_ff @(posedge clock) begin
      if (reset) begin
         bcfg_ff     <= BCFG_W'(BUCKETS);
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         if (csr_write) begin
            bcfg_ff <= csr_data;
         end
         if (ctl.clear_start) begin
            clr_ff      <= '0;
            clr_busy_ff <= 1'b1;
         end else if (clr_busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (32'(clr_ff) == BUCKETS - 1) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   // restoring remainder, one key bit per cycle
   assign rem_sh = {rem_ff, key_ff[KEY_W-1]};
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
      end else if (ctl.load) begin
         mod_busy_ff <= 1'b1;
      end else if (mod_busy_ff && step_ff == SW'(KEY_W - 1)) begin
         mod_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= req_command;
         key_ff  <= req_key;
         val_ff  <= req_value;
         rem_ff  <= '0;
         step_ff <= '0;
         div_ff  <= div_eff;
      end else if (mod_busy_ff) begin
         key_ff  <= {key_ff[KEY_W-2:0], key_ff[KEY_W-1]};
         step_ff <= step_ff + 1'b1;
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_ff <= NW'(rem_sh - {1'b0, div_ff});
         end else begin
            rem_ff <= NW'(rem_sh);
         end
      end
   end

   // head memory: clear, read, write
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         head_mem[BW'(clr_ff)] <= NIL;
      end else if (ctl.commit && hit_ff && is_remove && prev_ff == NIL) begin
         head_mem[bucket] <= hit_link_ff;
      end else if (ctl.commit && is_put_new && free_ff != NIL) begin
         head_mem[bucket] <= free_ff;
      end
      if (ctl.head_read) begin
         head_rd_ff <= head_mem[bucket];
      end
   end

   assign is_put_new = (cmd_ff == CMD_PUT) && !hit_ff;
   assign is_remove  = (cmd_ff == CMD_REMOVE);

   // entry pool: read current slot, write on update
   always_ff @(posedge clock) begin
      if (ctl.entry_read) begin
         ekey_rd_ff  <= key_mem[cur_idx];
         eval_rd_ff  <= val_mem[cur_idx];
         elink_rd_ff <= link_mem[cur_idx];
      end
      if (ctl.commit) begin
         if (hit_ff && cmd_ff == CMD_PUT) begin
            val_mem[cur_idx] <= val_ff;
         end else if (is_put_new && free_ff != NIL) begin
            key_mem[free_idx]  <= key_ff;
            val_mem[free_idx]  <= val_ff;
            link_mem[free_idx] <= head_rd_ff;
         end else if (hit_ff && is_remove && prev_ff != NIL) begin
            link_mem[prev_idx] <= hit_link_ff;
         end
      end
   end

   // chain walk
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         hit_ff <= 1'b0;
      end else if (ctl.head_take) begin
         cur_ff  <= head_rd_ff;
         prev_ff <= NIL;
         walk_ff <= '0;
      end else if (ctl.entry_check) begin
         if (valid_ff[cur_idx] && ekey_rd_ff == key_ff) begin
            hit_ff      <= 1'b1;
            hit_link_ff <= elink_rd_ff;
            hit_val_ff  <= eval_rd_ff;
         end else begin
            prev_ff <= cur_ff;
            cur_ff  <= elink_rd_ff;
            walk_ff <= walk_ff + 1'b1;
         end
      end
   end

   // free slot scan, lowest index first
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
      end else if (ctl.free_start) begin
         scan_busy_ff <= (cmd_ff == CMD_PUT);
      end else if (scan_busy_ff) begin
         if (!valid_ff[IW'(scan_ff)] || 32'(scan_ff) == POOL_ENTRIES - 1) begin
            scan_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.free_start) begin
         scan_ff <= '0;
         free_ff <= NIL;
      end else if (scan_busy_ff) begin
         scan_ff <= scan_ff + 1'b1;
         if (!valid_ff[IW'(scan_ff)]) begin
            free_ff <= PW'(scan_ff);
         end
      end
   end

   // valid map and count
   always_ff @(posedge clock) begin
      if (reset || ctl.clear_start) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (ctl.commit) begin
         if (is_put_new && free_ff != NIL) begin
            valid_ff[free_idx] <= 1'b1;
            count_ff           <= count_ff + 1'b1;
         end else if (hit_ff && is_remove) begin
            valid_ff[cur_idx] <= 1'b0;
            count_ff          <= count_ff - 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.respond;
      end
      if (ctl.respond) begin
         rsp_found_ff  <= hit_ff && cmd_ok;
         rsp_data_ff   <= (hit_ff && cmd_ok) ? hit_val_ff : '0;
         rsp_status_ff <= cmd_ok && is_put_new && free_ff == NIL;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = count_ff;

   assign sts.clear_done = !clr_busy_ff;
   assign sts.mod_done   = !mod_busy_ff;
   assign sts.cur_null   = (cur_ff >= NIL) || (32'(walk_ff) >= POOL_ENTRIES);
   assign sts.hit        = valid_ff[cur_idx] && ekey_rd_ff == key_ff;
   assign sts.free_done  = !scan_busy_ff;
   assign sts.cmd_valid  = cmd_ok;

endmodule
